>>> sv/rau_pkg.sv
// shared types, operation codes and defaults for the rational arithmetic unit
package rau_pkg;

    // default width of one fraction term
    localparam int TERM_WIDTH_DEF = 32;

    // operation codes
    localparam int REQ_TYPE_W = 3;
    typedef logic [REQ_TYPE_W-1:0] t_req_type;
    localparam t_req_type OP_ADD      = 3'd0;
    localparam t_req_type OP_SUBTRACT = 3'd1;
    localparam t_req_type OP_MULTIPLY = 3'd2;
    localparam t_req_type OP_DIVIDE   = 3'd3;
    localparam t_req_type OP_REDUCE   = 3'd4;

    // cross products held by the datapath
    localparam int NUM_PROD = 4;
    typedef logic [$clog2(NUM_PROD)-1:0] t_prod_idx;
    localparam t_prod_idx PROD_P = 2'd0;  // num_a * den_b
    localparam t_prod_idx PROD_Q = 2'd1;  // num_b * den_a
    localparam t_prod_idx PROD_S = 2'd2;  // den_a * den_b
    localparam t_prod_idx PROD_T = 2'd3;  // num_a * num_b, or den_a * num_b for divide

    // half-width partial products per full product
    localparam int MUL_STEPS = 4;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_GCD,
        S_DIV,
        S_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic      load;
        t_prod_idx mul_idx;
        logic      mul_hi_a;
        logic      mul_hi_b;
        logic      mul_clr;
        logic      mul_acc;
        logic      mul_store;
        logic      gcd_step;
        logic      div_init;
        logic      div_step;
        logic      res_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic op_reduce;
        logic gcd_done;
        logic gcd_zero;
    } t_dp_status;

endpackage

>>> sv/rau_req_if.sv
// request channel: operation and the two input fractions
interface rau_req_if #(
    parameter int TERM_WIDTH = rau_pkg::TERM_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    rau_pkg::t_req_type           req_type;
    logic signed [TERM_WIDTH-1:0] num_a;
    logic signed [TERM_WIDTH-1:0] den_a;
    logic signed [TERM_WIDTH-1:0] num_b;
    logic signed [TERM_WIDTH-1:0] den_b;

    modport source (
        output valid, req_type, num_a, den_a, num_b, den_b,
        input  ready
    );
    modport sink (
        input  valid, req_type, num_a, den_a, num_b, den_b,
        output ready
    );
endinterface

>>> sv/rau_rsp_if.sv
// response channel: result fraction, flags and comparison of A with B
interface rau_rsp_if #(
    parameter int TERM_WIDTH = rau_pkg::TERM_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [TERM_WIDTH-1:0] num_out;
    logic signed [TERM_WIDTH-1:0] den_out;
    logic                         overflow;
    logic                         undefined;
    logic                         a_less;
    logic                         a_equal;
    logic                         a_greater;

    modport source (
        output valid, num_out, den_out, overflow, undefined, a_less, a_equal, a_greater,
        input  ready
    );
    modport sink (
        input  valid, num_out, den_out, overflow, undefined, a_less, a_equal, a_greater,
        output ready
    );
endinterface

>>> sv/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit: controller and datapath
//
//   channel   direction  handshake              payload
//   i_req     in         i_req.valid/ready      req_type, num_a, den_a, num_b, den_b
//   o_rsp     out        o_rsp.valid/ready      num_out, den_out, overflow, undefined,
//                                               a_less, a_equal, a_greater
//
// one transaction at a time; add, subtract, multiply and divide each form four cross products,
// each from four half-width partial products. reduce adds the binary gcd, whose steps run
// alongside the products and go on after them until the gcd is found, and TERM_WIDTH quotient
// steps, one per term bit; a zero gcd skips the quotient steps.
// a finished result waits in the output register while the next request is accepted; a
// second result waits in the controller, and no request is taken until the register frees.
// reset is synchronous, active low, and clears the controller and output valid.
module rational_arithmetic_unit #(
    parameter int TERM_WIDTH = rau_pkg::TERM_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_req_if.sink   i_req,
    rau_rsp_if.source o_rsp
);
    rau_pkg::t_dp_cmd    cmd;
    rau_pkg::t_dp_status status;

    // sequencing
    rau_ctrl #(
        .TERM_WIDTH(TERM_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic
    rau_dpath #(
        .TERM_WIDTH(TERM_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_req_type  (i_req.req_type),
        .i_num_a     (i_req.num_a),
        .i_den_a     (i_req.den_a),
        .i_num_b     (i_req.num_b),
        .i_den_b     (i_req.den_b),
        .o_status    (status),
        .o_num_out   (o_rsp.num_out),
        .o_den_out   (o_rsp.den_out),
        .o_overflow  (o_rsp.overflow),
        .o_undefined (o_rsp.undefined),
        .o_a_less    (o_rsp.a_less),
        .o_a_equal   (o_rsp.a_equal),
        .o_a_greater (o_rsp.a_greater)
    );
endmodule

>>> sv/rau_ctrl.sv
// controller: sequences products, gcd, quotient steps and the result register
module rau_ctrl #(
    parameter int TERM_WIDTH = rau_pkg::TERM_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  rau_pkg::t_dp_status i_status,
    output rau_pkg::t_dp_cmd    o_cmd
);
    localparam int CNT_W = $clog2(TERM_WIDTH);

    rau_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    rau_pkg::t_prod_idx r_midx, n_midx;
    logic               r_out_valid, n_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rau_pkg::S_IDLE;
            r_cnt       <= '0;
            r_midx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_midx      <= n_midx;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_midx         = r_midx;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.mul_idx  = r_midx;
        o_cmd.mul_hi_a = r_cnt[0];
        o_cmd.mul_hi_b = r_cnt[1];
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_midx     = '0;
                    n_state    = rau_pkg::S_MUL;
                end
            end
            rau_pkg::S_MUL: begin
                // gcd runs alongside the products
                o_cmd.gcd_step = 1'b1;
                o_cmd.mul_clr  = (r_cnt == '0);
                o_cmd.mul_acc  = (r_cnt != '0);
                if (r_cnt == CNT_W'(rau_pkg::MUL_STEPS)) begin
                    o_cmd.mul_store = 1'b1;
                    n_cnt           = '0;
                    n_midx          = r_midx + 1'b1;
                    if (r_midx == rau_pkg::PROD_T) begin
                        n_state = i_status.op_reduce ? rau_pkg::S_GCD : rau_pkg::S_FINISH;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rau_pkg::S_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_status.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = i_status.gcd_zero ? rau_pkg::S_FINISH : rau_pkg::S_DIV;
                end
            end
            rau_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TERM_WIDTH - 1)) begin
                    n_state = rau_pkg::S_FINISH;
                end
            end
            rau_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = rau_pkg::S_IDLE;
                end
            end
            default: n_state = rau_pkg::S_IDLE;
        endcase
    end

    // result register occupancy
    always_comb begin
        n_out_valid = o_cmd.res_load | (r_out_valid & ~i_out_ready);
    end

    assign o_out_valid = r_out_valid;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // quotient phase ends after the step for the last term bit
    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rau_pkg::S_DIV && r_cnt == CNT_W'(TERM_WIDTH - 1))
        |=> (r_state == rau_pkg::S_FINISH))
        else $error("divide phase length wrong");

    // a fresh transaction always starts at the first product
    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == rau_pkg::S_MUL && r_cnt == '0 && r_midx == rau_pkg::PROD_P))
        else $error("product sequence did not restart");

    // loading a result leaves it visible and the controller ready
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> (o_out_valid && o_in_ready))
        else $error("result not presented after load");
endmodule

>>> sv/rau_dpath.sv
// datapath: operand registers, split multiplier, binary gcd, dividers, result register
module rau_dpath #(
    parameter int TERM_WIDTH = rau_pkg::TERM_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  rau_pkg::t_dp_cmd             i_cmd,
    input  rau_pkg::t_req_type           i_req_type,
    input  logic signed [TERM_WIDTH-1:0] i_num_a,
    input  logic signed [TERM_WIDTH-1:0] i_den_a,
    input  logic signed [TERM_WIDTH-1:0] i_num_b,
    input  logic signed [TERM_WIDTH-1:0] i_den_b,
    output rau_pkg::t_dp_status          o_status,
    output logic signed [TERM_WIDTH-1:0] o_num_out,
    output logic signed [TERM_WIDTH-1:0] o_den_out,
    output logic                         o_overflow,
    output logic                         o_undefined,
    output logic                         o_a_less,
    output logic                         o_a_equal,
    output logic                         o_a_greater
);
    localparam int W  = TERM_WIDTH;
    localparam int H  = (W + 1) / 2;
    localparam int HH = 2 * H;
    localparam int WW = 2 * W;
    localparam int KW = $clog2(W);

    // operand registers
    rau_pkg::t_req_type r_req_type;
    logic [W-1:0] r_num_a, r_den_a, r_num_b, r_den_b;
    logic [W-1:0] r_mag_na, r_mag_da, r_mag_nb, r_mag_db;
    logic [W-1:0] mag_na_n, mag_da_n;

    assign mag_na_n = i_num_a[W-1] ? -i_num_a : i_num_a;
    assign mag_da_n = i_den_a[W-1] ? -i_den_a : i_den_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_num_a    <= i_num_a;
            r_den_a    <= i_den_a;
            r_num_b    <= i_num_b;
            r_den_b    <= i_den_b;
            r_mag_na   <= mag_na_n;
            r_mag_da   <= mag_da_n;
            r_mag_nb   <= i_num_b[W-1] ? -i_num_b : i_num_b;
            r_mag_db   <= i_den_b[W-1] ? -i_den_b : i_den_b;
        end
    end

    // multiplier operand selection
    logic [W-1:0] mul_a, mul_b;
    logic         mul_neg;

    always_comb begin
        mul_a   = r_mag_na;
        mul_b   = r_mag_db;
        mul_neg = r_num_a[W-1] ^ r_den_b[W-1];
        case (i_cmd.mul_idx)
            rau_pkg::PROD_P: begin
                mul_a   = r_mag_na;
                mul_b   = r_mag_db;
                mul_neg = r_num_a[W-1] ^ r_den_b[W-1];
            end
            rau_pkg::PROD_Q: begin
                mul_a   = r_mag_nb;
                mul_b   = r_mag_da;
                mul_neg = r_num_b[W-1] ^ r_den_a[W-1];
            end
            rau_pkg::PROD_S: begin
                mul_a   = r_mag_da;
                mul_b   = r_mag_db;
                mul_neg = r_den_a[W-1] ^ r_den_b[W-1];
            end
            default: begin
                if (r_req_type == rau_pkg::OP_DIVIDE) begin
                    mul_a   = r_mag_da;
                    mul_neg = r_den_a[W-1] ^ r_num_b[W-1];
                end else begin
                    mul_a   = r_mag_na;
                    mul_neg = r_num_a[W-1] ^ r_num_b[W-1];
                end
                mul_b = r_mag_nb;
            end
        endcase
    end

    // half-width partial product, registered before accumulation
    logic [H-1:0]  half_a, half_b;
    logic [HH-1:0] r_pp;
    logic [1:0]    r_pp_sh;
    logic          r_pp_neg;

    assign half_a = i_cmd.mul_hi_a ? H'(mul_a[W-1:H]) : mul_a[H-1:0];
    assign half_b = i_cmd.mul_hi_b ? H'(mul_b[W-1:H]) : mul_b[H-1:0];

    always_ff @(posedge i_clk) begin
        r_pp     <= HH'(half_a) * HH'(half_b);
        r_pp_sh  <= {i_cmd.mul_hi_a & i_cmd.mul_hi_b, i_cmd.mul_hi_a ^ i_cmd.mul_hi_b};
        r_pp_neg <= mul_neg;
    end

    // signed accumulation of shifted partial products
    logic [WW-1:0] r_acc, pp_ext, pp_shifted, acc_n;
    logic signed [WW-1:0] r_prod [rau_pkg::NUM_PROD];

    assign pp_ext     = WW'(r_pp);
    assign pp_shifted = r_pp_sh[1] ? (pp_ext << (2 * H)) :
                        r_pp_sh[0] ? (pp_ext << H) : pp_ext;
    assign acc_n      = r_pp_neg ? (r_acc - pp_shifted) : (r_acc + pp_shifted);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_clr) begin
            r_acc <= '0;
        end else if (i_cmd.mul_acc) begin
            r_acc <= acc_n;
        end
        if (i_cmd.mul_store) begin
            r_prod[i_cmd.mul_idx] <= acc_n;
        end
    end

    // binary gcd of the magnitudes of A
    logic [W-1:0]  r_u, r_v, gcd_val;
    logic [KW-1:0] r_k;
    logic          gcd_done;

    assign gcd_done = (r_u == '0) || (r_v == '0);
    assign gcd_val  = (r_u | r_v) << r_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u <= mag_na_n;
            r_v <= mag_da_n;
            r_k <= '0;
        end else if (i_cmd.gcd_step && !gcd_done) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= r_v;
                r_v <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
    end

    assign o_status.op_reduce = (r_req_type == rau_pkg::OP_REDUCE);
    assign o_status.gcd_done  = gcd_done;
    assign o_status.gcd_zero  = (r_u == '0) && (r_v == '0);

    // restoring dividers for both terms, one quotient bit per cycle
    logic [W-1:0] r_dvs, r_qa, r_qb, r_ra, r_rb;
    logic [W:0]   dvs_ext, trial_a, trial_b, diff_a, diff_b;
    logic         take_a, take_b;

    assign dvs_ext = {1'b0, r_dvs};
    assign trial_a = {r_ra, r_qa[W-1]};
    assign trial_b = {r_rb, r_qb[W-1]};
    assign diff_a  = trial_a - dvs_ext;
    assign diff_b  = trial_b - dvs_ext;
    assign take_a  = (trial_a >= dvs_ext);
    assign take_b  = (trial_b >= dvs_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dvs <= gcd_val;
            r_qa  <= r_mag_na;
            r_qb  <= r_mag_da;
            r_ra  <= '0;
            r_rb  <= '0;
        end else if (i_cmd.div_step) begin
            r_ra <= take_a ? diff_a[W-1:0] : trial_a[W-1:0];
            r_rb <= take_b ? diff_b[W-1:0] : trial_b[W-1:0];
            r_qa <= {r_qa[W-2:0], take_a};
            r_qb <= {r_qb[W-2:0], take_b};
        end
    end

    // result selection
    logic signed [WW-1:0] prod_p, prod_q, prod_s, prod_t;
    logic signed [WW:0]   sum_pq;
    logic                 red_neg, flip, less_n, equal_n;
    logic [W-1:0]         num_n, den_n;
    logic                 ovf_n, undef_n;

    assign prod_p  = r_prod[rau_pkg::PROD_P];
    assign prod_q  = r_prod[rau_pkg::PROD_Q];
    assign prod_s  = r_prod[rau_pkg::PROD_S];
    assign prod_t  = r_prod[rau_pkg::PROD_T];
    assign sum_pq  = (r_req_type == rau_pkg::OP_SUBTRACT) ?
                     ({prod_p[WW-1], prod_p} - {prod_q[WW-1], prod_q}) :
                     ({prod_p[WW-1], prod_p} + {prod_q[WW-1], prod_q});
    assign red_neg = r_num_a[W-1] ^ r_den_a[W-1];
    assign flip    = r_den_a[W-1] ^ r_den_b[W-1];
    assign equal_n = (prod_p == prod_q);
    assign less_n  = flip ? (prod_q < prod_p) : (prod_p < prod_q);

    always_comb begin
        case (r_req_type) inside
            rau_pkg::OP_ADD, rau_pkg::OP_SUBTRACT: begin
                num_n   = sum_pq[W-1:0];
                den_n   = prod_s[W-1:0];
                ovf_n   = !((&sum_pq[WW:W-1]) || !(|sum_pq[WW:W-1])) ||
                          !((&prod_s[WW-1:W-1]) || !(|prod_s[WW-1:W-1]));
                undef_n = (prod_s == '0);
            end
            rau_pkg::OP_MULTIPLY: begin
                num_n   = prod_t[W-1:0];
                den_n   = prod_s[W-1:0];
                ovf_n   = !((&prod_t[WW-1:W-1]) || !(|prod_t[WW-1:W-1])) ||
                          !((&prod_s[WW-1:W-1]) || !(|prod_s[WW-1:W-1]));
                undef_n = (prod_s == '0);
            end
            rau_pkg::OP_DIVIDE: begin
                num_n   = prod_p[W-1:0];
                den_n   = prod_t[W-1:0];
                ovf_n   = !((&prod_p[WW-1:W-1]) || !(|prod_p[WW-1:W-1])) ||
                          !((&prod_t[WW-1:W-1]) || !(|prod_t[WW-1:W-1]));
                undef_n = (prod_t == '0);
            end
            rau_pkg::OP_REDUCE: begin
                // quotients are magnitudes; only +2^(W-1) fails to fit
                num_n   = red_neg ? -r_qa : r_qa;
                den_n   = r_qb;
                ovf_n   = (r_qa[W-1] && !red_neg) || r_qb[W-1];
                undef_n = (r_qb == '0);
            end
            default: begin
                num_n   = r_num_a;
                den_n   = r_den_a;
                ovf_n   = 1'b0;
                undef_n = (r_den_a == '0);
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_num_out   <= num_n;
            o_den_out   <= den_n;
            o_overflow  <= ovf_n;
            o_undefined <= undef_n;
            o_a_less    <= less_n;
            o_a_equal   <= equal_n;
            o_a_greater <= !less_n && !equal_n;
        end
    end

    // a nonzero gcd term u never collapses to zero
    a_gcd_nonzero: assert property (@(posedge i_clk)
        (i_cmd.gcd_step && !i_cmd.load && r_u != '0) |=> (r_u != '0))
        else $error("gcd term became zero");

    // partial remainders stay below the divisor
    a_rem_bound: assert property (@(posedge i_clk)
        i_cmd.div_step |=> ((r_ra < r_dvs) && (r_rb < r_dvs)))
        else $error("divider remainder out of range");

    // the divisor is the nonzero gcd whenever division is started
    a_dvs_nonzero: assert property (@(posedge i_clk)
        (i_cmd.div_init && !o_status.gcd_zero) |=> (r_dvs != '0))
        else $error("zero divisor loaded");
endmodule
